// ----- rtl/sacte_pkg.sv -----
package sacte_pkg;

  // Fixed widths and bounds of the address split, and widths of the age and the totals.
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TAG_W       = 30;
  localparam int unsigned RAW_SET_W   = 10;
  localparam int unsigned MAX_IDX     = 10;
  localparam int unsigned MIN_OFS     = 2;
  localparam int unsigned AGE_W       = 4;
  localparam int unsigned DIRTY_CNT_W = 14;
  localparam int unsigned CNT_W       = 32;

  // Parameter defaults.
  localparam int unsigned DEF_SETS = 1024;
  localparam int unsigned DEF_WAYS = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_OFFSET  = 2'd1;
  localparam logic [1:0] CFG_INDEX   = 2'd2;
  localparam logic [1:0] CFG_WAYS    = 2'd3;

  // Replacement policies.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Access kinds.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        writeback;
    logic [2:0]  way;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] writeback_total;
    logic [13:0] dirty_lines;
  } out_t;

  // One way of a set as kept in the set memory.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } line_t;

  // Remainder of a narrow set number by a constant modulus, one
  // compare and subtract per power-of-two multiple of the modulus.
  function automatic logic [RAW_SET_W-1:0] mod_const(logic [RAW_SET_W-1:0] v,
                                                     int unsigned m);
    logic [RAW_SET_W-1:0] r;
    int unsigned          sub;
    r = v;
    for (int k = RAW_SET_W - 1; k >= 0; k--) begin
      sub = m << k;
      if (sub < (1 << RAW_SET_W)) begin
        if (32'(r) >= sub) begin
          r = r - RAW_SET_W'(sub);
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/set_assoc_cache_tag_engine_core.sv -----
// An accepted access passes the index state (set split and set read), then the update
// state, which writes the set back and registers the result. A stalled result holds the
// update, and no new access is taken before it; the set memory's read and its write-back
// of the whole set bound the access rate. Reset: asynchronous, active low. Afterwards
// the block sweeps every set to clear valid, dirty and age state, accepting no access meanwhile.
module set_assoc_cache_tag_engine_core #(
  parameter int unsigned SETS = sacte_pkg::DEF_SETS,
  parameter int unsigned WAYS = sacte_pkg::DEF_WAYS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sacte_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sacte_pkg::out_t  out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [3:0]       cfg_wdata_i
);

  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W  = WAYS * $bits(sacte_pkg::line_t);
  localparam int unsigned NW_W   = $clog2(WAYS + 1) + 1;

  typedef sacte_pkg::line_t [WAYS-1:0] row_t;

  sacte_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic       policy_q;
  logic [2:0] ofs_q;
  logic [3:0] idx_q;
  logic [3:0] ways_q;

  // Access in flight and the clear sweep pointer.
  sacte_pkg::in_t                 req_q;
  logic [SET_W-1:0]               set_q, set_d;
  logic [sacte_pkg::TAG_W-1:0]    tag_q, tag_d;
  logic [SET_W-1:0]               clr_q;

  // Running totals.
  logic [31:0] hit_cnt_q, miss_cnt_q, wb_cnt_q;
  logic [31:0] hit_cnt_d, miss_cnt_d, wb_cnt_d;
  logic [13:0] dirty_cnt_q, dirty_cnt_d;

  // Result register.
  logic            out_valid_q;
  sacte_pkg::out_t out_q, res_d;

  logic in_accept, upd_go, clr_done;
  logic ram_we, ram_re;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  row_t row_rd, row_wr;

  assign upd_go    = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;
  assign clr_done  = (32'(clr_q) == SETS - 1);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= sacte_pkg::POLICY_LRU;
      ofs_q    <= 3'd5;
      idx_q    <= 4'd8;
      ways_q   <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sacte_pkg::CFG_POLICY: policy_q <= cfg_wdata_i[0];
        sacte_pkg::CFG_OFFSET: ofs_q    <= cfg_wdata_i[2:0];
        sacte_pkg::CFG_INDEX:  idx_q    <= cfg_wdata_i;
        sacte_pkg::CFG_WAYS:   ways_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sacte_pkg::ST_CLEAR: if (clr_done) state_d = sacte_pkg::ST_IDLE;
      sacte_pkg::ST_IDLE:  if (in_valid_i) state_d = sacte_pkg::ST_INDEX;
      sacte_pkg::ST_INDEX: state_d = sacte_pkg::ST_UPDATE;
      sacte_pkg::ST_UPDATE: begin
        if (upd_go) begin
          state_d = in_valid_i ? sacte_pkg::ST_INDEX : sacte_pkg::ST_IDLE;
        end
      end
      default: state_d = sacte_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = set_q;
    ram_wdata  = row_wr;
    unique case (state_q)
      sacte_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      sacte_pkg::ST_IDLE:  in_stall_o = 1'b0;
      sacte_pkg::ST_INDEX: ram_re = 1'b1;
      sacte_pkg::ST_UPDATE: begin
        in_stall_o = !upd_go;
        ram_we     = upd_go;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacte_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == sacte_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Split the address into set and tag.
  always_comb begin
    logic [2:0]                       ob;
    logic [3:0]                       ib;
    logic [31:0]                      shifted;
    logic [sacte_pkg::RAW_SET_W:0]    mask;
    logic [sacte_pkg::RAW_SET_W-1:0]  raw;
    ob      = (ofs_q < 3'(sacte_pkg::MIN_OFS)) ? 3'(sacte_pkg::MIN_OFS) : ofs_q;
    ib      = (idx_q > 4'(sacte_pkg::MAX_IDX)) ? 4'(sacte_pkg::MAX_IDX) : idx_q;
    shifted = req_q.address >> ob;
    mask    = (11'd1 << ib) - 11'd1;
    raw     = shifted[sacte_pkg::RAW_SET_W-1:0] & mask[sacte_pkg::RAW_SET_W-1:0];
    set_d   = SET_W'(sacte_pkg::mod_const(raw, SETS));
    tag_d   = sacte_pkg::TAG_W'(req_q.address >> (5'(ob) + 5'(ib)));
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (state_q == sacte_pkg::ST_INDEX) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  sacte_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_d),
    .rdata_o (ram_rdata)
  );

  assign row_rd = row_t'(ram_rdata);

  // Tag compare, victim choice and the modified set.
  always_comb begin
    logic [NW_W-1:0]            nways;
    logic [WAYS-1:0]            in_use;
    logic                       hit, found, is_wr, wb, upd_age, all_age;
    logic [WIDX_W-1:0]          hit_way, inv_way, old_way, pick;
    logic [sacte_pkg::AGE_W-1:0] oldest, limit;
    nways   = (ways_q == 4'd0) ? NW_W'(1) : NW_W'(ways_q);
    if (nways > NW_W'(WAYS)) nways = NW_W'(WAYS);
    is_wr   = (req_q.kind == sacte_pkg::KIND_WRITE);
    hit     = 1'b0;
    found   = 1'b0;
    hit_way = '0;
    inv_way = '0;
    old_way = '0;
    oldest  = '0;
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (NW_W'(w) < nways);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && row_rd[w].valid && row_rd[w].tag == tag_q) begin
        hit     = 1'b1;
        hit_way = WIDX_W'(w);
      end
      if (in_use[w] && !row_rd[w].valid) begin
        found   = 1'b1;
        inv_way = WIDX_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (in_use[w] && row_rd[w].age > oldest) begin
        oldest  = row_rd[w].age;
        old_way = WIDX_W'(w);
      end
    end
    pick    = hit ? hit_way : (found ? inv_way : old_way);
    limit   = hit ? row_rd[hit_way].age : oldest;
    all_age = !hit && found;
    upd_age = !hit || (policy_q == sacte_pkg::POLICY_LRU);
    wb      = !hit && row_rd[pick].valid && row_rd[pick].dirty;

    // On a miss or LRU hit, age younger valid ways (all if an empty way is filled); make the pick youngest.
    row_wr = row_rd;
    if (upd_age) begin
      for (int w = 0; w < WAYS; w++) begin
        if (in_use[w] && WIDX_W'(w) != pick && row_rd[w].valid &&
            (all_age || row_rd[w].age < limit)) begin
          row_wr[w].age = row_rd[w].age + 1'b1;
        end
      end
      row_wr[pick].age = '0;
    end

    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    wb_cnt_d    = wb_cnt_q;
    dirty_cnt_d = dirty_cnt_q;
    if (hit) begin
      if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + 1'b1;
      if (is_wr && !row_rd[pick].dirty) begin
        row_wr[pick].dirty = 1'b1;
        dirty_cnt_d        = dirty_cnt_q + 1'b1;
      end
    end else begin
      if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + 1'b1;
      if (wb) begin
        if (wb_cnt_q != '1) wb_cnt_d = wb_cnt_q + 1'b1;
        if (dirty_cnt_q != '0) dirty_cnt_d = dirty_cnt_q - 1'b1;
      end
      row_wr[pick].tag   = tag_q;
      row_wr[pick].valid = 1'b1;
      row_wr[pick].dirty = is_wr;
      if (is_wr) dirty_cnt_d = dirty_cnt_d + 1'b1;
    end

    res_d.hit             = hit;
    res_d.writeback       = wb;
    res_d.way             = 3'(pick);
    res_d.hit_total       = hit_cnt_d;
    res_d.miss_total      = miss_cnt_d;
    res_d.writeback_total = wb_cnt_d;
    res_d.dirty_lines     = dirty_cnt_d;
  end

  // Totals and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      wb_cnt_q    <= '0;
      dirty_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else if (state_q == sacte_pkg::ST_UPDATE && upd_go) begin
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      wb_cnt_q    <= wb_cnt_d;
      dirty_cnt_q <= dirty_cnt_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sacte_pkg::ST_UPDATE && upd_go) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/sacte_ram.sv -----
module sacte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/sacte_check.sv -----
module sacte_check (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input sacte_pkg::out_t out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A hit never evicts.
  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.writeback))
    else $error("hit reported with writeback");

  // Every result has been counted.
  a_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hit_total != '0 || out_data_o.miss_total != '0))
    else $error("result without a counted access");

  // Hit and writeback totals never fall from one transfer to the next result.
  a_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) ##1 out_valid_o |->
      out_data_o.hit_total >= $past(out_data_o.hit_total) &&
      out_data_o.writeback_total >= $past(out_data_o.writeback_total))
    else $error("running total decreased");

  // An input transfer is always followed by a stall, as the engine then stands in the index state.
  a_in_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input transfers in consecutive cycles");

endmodule

bind set_assoc_cache_tag_engine_core sacte_check u_sacte_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- tb/sv/set_assoc_cache_tag_engine_core_tb.sv -----
module set_assoc_cache_tag_engine_core_tb;

  localparam int unsigned NSETS = 1024;
  localparam int unsigned NWAYS = 8;
  localparam int unsigned NLINES = NSETS * NWAYS;

  // Kind three has no name in the block and acts as a read.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  sacte_pkg::in_t    in_data;
  logic              out_valid;
  logic              out_stall;
  sacte_pkg::out_t   out_data;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [3:0]        cfg_wdata;

  // Cache shadow state.
  logic [31:0] shadow_tag [NLINES];
  bit          shadow_valid [NLINES];
  bit          shadow_dirty [NLINES];
  int unsigned shadow_age [NLINES];
  logic [31:0] hits_seen, misses_seen, wbs_seen;
  int unsigned dirty_count;
  logic        pol_reg;
  logic [2:0]  ofs_reg;
  logic [3:0]  idx_reg;
  logic [3:0]  ways_reg;

  sacte_pkg::out_t pending_results [$];
  int unsigned mismatches;
  int unsigned transfers_in, transfers_out;
  bit          timed_out;
  bit          hold_off;
  int unsigned stall_pct;

  set_assoc_cache_tag_engine_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Age every valid way in use that is younger than the limit, then make the pick youngest.
  function automatic void refresh_age(int unsigned base, int unsigned nw, int unsigned pick,
                                      int unsigned limit);
    for (int unsigned w = 0; w < nw; w++) begin
      if (w != pick && shadow_valid[base+w] && shadow_age[base+w] < limit &&
          shadow_age[base+w] < 255) begin
        shadow_age[base+w]++;
      end
    end
    shadow_age[base+pick] = 0;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Work out the result of one access and update the shadow state.
  function automatic sacte_pkg::out_t predict_access(sacte_pkg::in_t acc);
    sacte_pkg::out_t res;
    int unsigned ob, ib, nw, set_no, base, way, limit, oldest, ln;
    logic [31:0] tag;
    bit          hit, wb, found, is_wr;
    ob = (ofs_reg < 2) ? 2 : ofs_reg;
    ib = (idx_reg > 10) ? 10 : idx_reg;
    nw = (ways_reg == 0) ? 1 : ways_reg;
    if (nw > NWAYS) nw = NWAYS;
    is_wr = (acc.kind == sacte_pkg::KIND_WRITE);
    set_no = ((acc.address >> ob) & ((32'd1 << ib) - 1)) % NSETS;
    tag = acc.address >> (ob + ib);
    base = set_no * NWAYS;
    hit = 1'b0;
    wb = 1'b0;
    way = 0;
    for (int unsigned w = 0; w < nw; w++) begin
      if (!hit && shadow_valid[base+w] && shadow_tag[base+w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (hit) begin
      ln = base + way;
      hits_seen = sat_add(hits_seen);
      if (pol_reg == sacte_pkg::POLICY_LRU) refresh_age(base, nw, way, shadow_age[ln]);
      if (is_wr && !shadow_dirty[ln]) begin
        shadow_dirty[ln] = 1'b1;
        dirty_count++;
      end
    end else begin
      misses_seen = sat_add(misses_seen);
      found = 1'b0;
      for (int unsigned w = 0; w < nw; w++) begin
        if (!found && !shadow_valid[base+w]) begin
          way = w;
          found = 1'b1;
        end
      end
      if (found) begin
        limit = 256;
      end else begin
        oldest = 0;
        way = 0;
        for (int unsigned w = 0; w < nw; w++) begin
          if (shadow_age[base+w] > oldest) begin
            oldest = shadow_age[base+w];
            way = w;
          end
        end
        limit = oldest;
      end
      ln = base + way;
      if (shadow_valid[ln] && shadow_dirty[ln]) begin
        wb = 1'b1;
        wbs_seen = sat_add(wbs_seen);
        shadow_dirty[ln] = 1'b0;
        if (dirty_count > 0) dirty_count--;
      end
      refresh_age(base, nw, way, limit);
      shadow_tag[ln] = tag;
      shadow_valid[ln] = 1'b1;
      if (is_wr) begin
        shadow_dirty[ln] = 1'b1;
        dirty_count++;
      end
    end
    res.hit = hit;
    res.writeback = wb;
    res.way = way[2:0];
    res.hit_total = hits_seen;
    res.miss_total = misses_seen;
    res.writeback_total = wbs_seen;
    res.dirty_lines = dirty_count[13:0];
    return res;
  endfunction

  // Offer one access and wait for its transfer; predict on acceptance.
  task automatic send_access(logic [1:0] kind, logic [31:0] addr);
    sacte_pkg::in_t acc;
    acc.kind = kind;
    acc.address = addr;
    in_valid <= 1'b1;
    in_data <= acc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_access(acc));
    transfers_in++;
    // Bursty sender: sometimes a gap after this transfer.
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drain all outstanding results, then let the engine idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one configuration register while the engine is idle; the caller drops the enable.
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sacte_pkg::CFG_POLICY: pol_reg = val[0];
      sacte_pkg::CFG_OFFSET: ofs_reg = val[2:0];
      sacte_pkg::CFG_INDEX:  idx_reg = val;
      default:               ways_reg = val;
    endcase
  endtask

  task automatic apply_setup(logic pol, logic [2:0] ofs, logic [3:0] idx, logic [3:0] nw);
    wait_idle();
    write_reg(sacte_pkg::CFG_POLICY, {3'b0, pol});
    write_reg(sacte_pkg::CFG_OFFSET, {1'b0, ofs});
    write_reg(sacte_pkg::CFG_INDEX, idx);
    write_reg(sacte_pkg::CFG_WAYS, nw);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return KIND_SPARE;
    if (r < 6) return sacte_pkg::KIND_WRITE;
    if (r < 10) return sacte_pkg::KIND_FETCH;
    return sacte_pkg::KIND_READ;
  endfunction

  // Directed: address extremes, every kind, fill then evict a dirty set.
  task automatic test_directed();
    apply_setup(sacte_pkg::POLICY_LRU, 3'd5, 4'd8, 4'd2);
    send_access(sacte_pkg::KIND_WRITE, 32'h0000_0000);
    send_access(sacte_pkg::KIND_READ, 32'h0000_0000);
    send_access(sacte_pkg::KIND_FETCH, 32'hFFFF_FFFF);
    send_access(KIND_SPARE, 32'hFFFF_FFFF);
    send_access(sacte_pkg::KIND_WRITE, 32'h0001_0000);
    send_access(sacte_pkg::KIND_WRITE, 32'h0002_0000);
    send_access(sacte_pkg::KIND_READ, 32'h0003_0000);
    send_access(sacte_pkg::KIND_WRITE, 32'hAAAA_AAAA);
    send_access(sacte_pkg::KIND_WRITE, 32'h5555_5555);
    // Out-of-range settings: small offset, large index, ways zero and above eight.
    apply_setup(sacte_pkg::POLICY_FIFO, 3'd0, 4'd15, 4'd0);
    send_access(sacte_pkg::KIND_WRITE, 32'h0000_0004);
    send_access(sacte_pkg::KIND_READ, 32'h0010_0004);
    send_access(sacte_pkg::KIND_READ, 32'h0000_0004);
    apply_setup(sacte_pkg::POLICY_FIFO, 3'd1, 4'd11, 4'd15);
    for (int i = 0; i < 10; i++) send_access(sacte_pkg::KIND_WRITE, i << 20);
    send_access(sacte_pkg::KIND_READ, 32'h0000_0000);
    // Fully associative with the largest block size.
    apply_setup(sacte_pkg::POLICY_LRU, 3'd7, 4'd0, 4'd8);
    send_access(sacte_pkg::KIND_WRITE, 32'h8000_0000);
    send_access(sacte_pkg::KIND_READ, 32'h8000_007F);
  endtask

  // Random accesses drawn from a small address pool so that hits and evictions occur.
  task automatic test_random(int unsigned count);
    logic [31:0] pool [16];
    logic [31:0] addr;
    int unsigned ob, ib;
    ob = (ofs_reg < 2) ? 2 : ofs_reg;
    ib = (idx_reg > 10) ? 10 : idx_reg;
    for (int i = 0; i < 16; i++) begin
      pool[i] = ($urandom_range(0, 11) << (ob + ib)) | ($urandom_range(0, 3) << ob);
    end
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) addr = $urandom();
      else addr = pool[$urandom_range(0, 15)] | ($urandom() & ((32'd1 << ob) - 1));
      send_access(pick_kind(), addr);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
  endtask

  // Receiver stall pattern: phases of heavy, light and no stalling.
  initial begin
    out_stall = 1'b0;
    stall_pct = 30;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) stall_pct = $urandom_range(0, 2) * 35;
      out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker.
  initial begin
    sacte_pkg::out_t exp_res;
    mismatches = 0;
    transfers_out = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        transfers_out++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %p", out_data);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_data !== exp_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d", transfers_out);
              $display("  expected %p", exp_res);
              $display("  actual   %p", out_data);
            end
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    timed_out = 1'b0;
    #40_000_000;
    timed_out = 1'b1;
    $display("set_assoc_cache_tag_engine_core test failed");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = sacte_pkg::CFG_POLICY;
    cfg_wdata = '0;
    hold_off = 1'b0;
    transfers_in = 0;
    hits_seen = '0;
    misses_seen = '0;
    wbs_seen = '0;
    dirty_count = 0;
    pol_reg = sacte_pkg::POLICY_LRU;
    ofs_reg = 3'd5;
    idx_reg = 4'd8;
    ways_reg = 4'd1;
    for (int i = 0; i < NLINES; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_age[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset setup first, then the directed cases.
    test_random(20);
    test_directed();
    apply_setup(sacte_pkg::POLICY_LRU, 3'd2, 4'd1, 4'd4);
    test_backpressure();
    for (int phase = 0; phase < 8; phase++) begin
      apply_setup($urandom_range(0, 1), $urandom_range(2, 7), $urandom_range(0, 10),
                  $urandom_range(1, 8));
      test_random(150);
    end
    apply_setup(sacte_pkg::POLICY_FIFO, 3'd7, 4'd10, 4'd8);
    test_random(80);
    apply_setup(sacte_pkg::POLICY_LRU, 3'd2, 4'd0, 4'd1);
    test_random(80);
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Covered %0d accesses over both policies, extreme and out-of-range settings,",
             transfers_in);
    $display("a long receiver hold-off, %0d hits, %0d misses, %0d writebacks.",
             hits_seen, misses_seen, wbs_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("set_assoc_cache_tag_engine_core test passed");
    end else begin
      $display("set_assoc_cache_tag_engine_core test failed");
    end
    $finish;
  end

endmodule
